[src/adpcm_nibble_decoder_assert.svh]
// Assertion macros used by the decoder top level.
`ifndef ADPCM_NIBBLE_DECODER_ASSERT_SVH
`define ADPCM_NIBBLE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define ANDEC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ANDEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/andec_pkg.sv]
package andec_pkg;

   localparam int MAX_STEP_INDEX_DEFAULT = 58;
   localparam int ADJ_DEPTH = 16;

   localparam logic signed [11:0] PRED_MIN = -12'sd2048;
   localparam logic signed [11:0] PRED_MAX = 12'sd2047;

   typedef enum logic [1:0] {
      KIND_DECODE  = 2'd0,
      KIND_STEP_WR = 2'd1,
      KIND_ADJ_WR  = 2'd2,
      KIND_RESTART = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         code_byte;
      logic [5:0]         table_addr;
      logic [14:0]        step_value;
      logic signed [7:0]  adjust_value;
      logic               block_end;
   } item_type;

   // Write and read control from the sequencer to the table memories.
   typedef struct packed {
      logic        step_we;
      logic        adj_we;
      logic [5:0]  wr_addr;
      logic [14:0] step_wdata;
      logic [7:0]  adj_wdata;
      logic        rd_en;
      logic [3:0]  adj_raddr;
   } tbl_req_type;

   typedef struct packed {
      logic take;
      logic busy;
   } core_status_type;

endpackage

[src/andec_if.sv]
interface andec_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [7:0]        code_byte;
   logic [5:0]        table_addr;
   logic [14:0]       step_value;
   logic signed [7:0] adjust_value;
   logic              block_end;

   modport source (
      output valid, kind, code_byte, table_addr, step_value, adjust_value, block_end,
      input  ready
   );
   modport sink (
      input  valid, kind, code_byte, table_addr, step_value, adjust_value, block_end,
      output ready
   );
endinterface

interface andec_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [11:0] first_sample;
   logic signed [11:0] second_sample;
   logic [10:0]        first_level;
   logic [10:0]        second_level;
   logic               block_end_out;

   modport source (
      output valid, first_sample, second_sample, first_level, second_level, block_end_out,
      input  ready
   );
   modport sink (
      input  valid, first_sample, second_sample, first_level, second_level, block_end_out,
      output ready
   );
endinterface

[src/andec_tables.sv]
module andec_tables #(
   parameter int MAX_STEP_INDEX = andec_pkg::MAX_STEP_INDEX_DEFAULT,
   parameter int IDX_W = $clog2(MAX_STEP_INDEX + 1)
) (
   input  logic                     clock,
   input  andec_pkg::tbl_req_type   tbl_req,
   input  logic [IDX_W-1:0]         step_raddr,
   output logic [14:0]              step_rdata,
   output logic signed [7:0]        adj_rdata
);
   import andec_pkg::*;

   logic [14:0] step_mem [MAX_STEP_INDEX+1];
   logic [7:0]  adj_mem  [ADJ_DEPTH];

   logic [14:0] step_rdata_ff;
   logic [7:0]  adj_rdata_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.step_we) begin
         step_mem[IDX_W'(tbl_req.wr_addr)] <= tbl_req.step_wdata;
      end
      if (tbl_req.rd_en) begin
         step_rdata_ff <= step_mem[step_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.adj_we) begin
         adj_mem[tbl_req.wr_addr[3:0]] <= tbl_req.adj_wdata;
      end
      if (tbl_req.rd_en) begin
         adj_rdata_ff <= adj_mem[tbl_req.adj_raddr];
      end
   end

   assign step_rdata = step_rdata_ff;
   assign adj_rdata  = $signed(adj_rdata_ff);

endmodule

[src/andec_core.sv]
module andec_core #(
   parameter int MAX_STEP_INDEX = andec_pkg::MAX_STEP_INDEX_DEFAULT,
   parameter int IDX_W = $clog2(MAX_STEP_INDEX + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  andec_pkg::item_type        cmd,
   output andec_pkg::core_status_type status,
   output andec_pkg::tbl_req_type     tbl_req,
   output logic [IDX_W-1:0]           step_raddr,
   input  logic [14:0]                step_rdata,
   input  logic signed [7:0]          adj_rdata,
   andec_rsp_if.source                rsp
);
   import andec_pkg::*;

   localparam int SUM_W = IDX_W + 9;
   localparam int CW = (IDX_W > 6) ? IDX_W + 1 : 7;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_FIRST  = 3'b010,
      ST_SECOND = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic signed [11:0] pred_ff, pred_in;
   logic [3:0]         hi_nib_ff, hi_nib_in;
   logic [3:0]         lo_nib_ff, lo_nib_in;
   logic               bend_ff, bend_in;
   logic signed [11:0] first_ff, first_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [11:0] rsp_first_ff, rsp_second_ff;
   logic               rsp_bend_ff;
   logic               rsp_load;

   logic [3:0]             nib_code;
   logic signed [SUM_W-1:0] idx_sum;
   logic [IDX_W-1:0]       nib_idx;
   logic [15:0]            diff;
   logic signed [17:0]     pred_sum;
   logic signed [11:0]     nib_pred;
   logic                   slot_free;

   // One nibble: new step index and new predictor from the registered table reads.
   always_comb begin
      nib_code = (state_ff == ST_FIRST) ? hi_nib_ff : lo_nib_ff;

      idx_sum = $signed({{(SUM_W-IDX_W){1'b0}}, idx_ff})
              + $signed({{(SUM_W-8){adj_rdata[7]}}, adj_rdata});
      if (idx_sum[SUM_W-1]) begin
         nib_idx = '0;
      end else if (idx_sum > $signed(SUM_W'(MAX_STEP_INDEX))) begin
         nib_idx = IDX_W'(MAX_STEP_INDEX);
      end else begin
         nib_idx = idx_sum[IDX_W-1:0];
      end

      diff = {4'b0, step_rdata[14:3]}
           + (nib_code[2] ? {1'b0, step_rdata} : 16'd0)
           + (nib_code[1] ? {2'b0, step_rdata[14:1]} : 16'd0)
           + (nib_code[0] ? {3'b0, step_rdata[14:2]} : 16'd0);

      if (nib_code[3]) begin
         pred_sum = 18'(pred_ff) - $signed({2'b0, diff});
      end else begin
         pred_sum = 18'(pred_ff) + $signed({2'b0, diff});
      end
      if (pred_sum < 18'(PRED_MIN)) begin
         nib_pred = PRED_MIN;
      end else if (pred_sum > 18'(PRED_MAX)) begin
         nib_pred = PRED_MAX;
      end else begin
         nib_pred = pred_sum[11:0];
      end
   end

   assign slot_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      pred_in   = pred_ff;
      hi_nib_in = hi_nib_ff;
      lo_nib_in = lo_nib_ff;
      bend_in   = bend_ff;
      first_in  = first_ff;
      rsp_load  = 1'b0;

      status.take = 1'b0;
      status.busy = (state_ff != ST_IDLE);

      tbl_req.step_we    = 1'b0;
      tbl_req.adj_we     = 1'b0;
      tbl_req.wr_addr    = cmd.table_addr;
      tbl_req.step_wdata = cmd.step_value;
      tbl_req.adj_wdata  = cmd.adjust_value;
      tbl_req.rd_en      = 1'b0;
      tbl_req.adj_raddr  = cmd.code_byte[7:4];
      step_raddr         = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               status.take = 1'b1;
               unique case (cmd.kind)
                  KIND_STEP_WR: begin
                     tbl_req.step_we = (CW'(cmd.table_addr) <= CW'(MAX_STEP_INDEX));
                  end
                  KIND_ADJ_WR: begin
                     tbl_req.adj_we = (cmd.table_addr < 6'(ADJ_DEPTH));
                  end
                  KIND_RESTART: begin
                     idx_in  = '0;
                     pred_in = '0;
                  end
                  KIND_DECODE: begin
                     tbl_req.rd_en = 1'b1;
                     hi_nib_in     = cmd.code_byte[7:4];
                     lo_nib_in     = cmd.code_byte[3:0];
                     bend_in       = cmd.block_end;
                     state_in      = ST_FIRST;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FIRST: begin
            // Read the second nibble's entries at the index just computed.
            tbl_req.rd_en     = 1'b1;
            tbl_req.adj_raddr = lo_nib_ff;
            step_raddr        = nib_idx;
            idx_in            = nib_idx;
            pred_in           = nib_pred;
            first_in          = nib_pred;
            state_in          = ST_SECOND;
         end
         ST_SECOND: begin
            // Hold until the output word is free.
            if (slot_free) begin
               idx_in   = nib_idx;
               pred_in  = nib_pred;
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         pred_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pred_ff      <= pred_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_nib_ff <= hi_nib_in;
      lo_nib_ff <= lo_nib_in;
      bend_ff   <= bend_in;
      first_ff  <= first_in;
      if (rsp_load) begin
         rsp_first_ff  <= first_ff;
         rsp_second_ff <= nib_pred;
         rsp_bend_ff   <= bend_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.first_sample  = rsp_first_ff;
   assign rsp.second_sample = rsp_second_ff;
   // (s + 2048) >> 1 is the offset-binary form without its lowest bit.
   assign rsp.first_level   = {~rsp_first_ff[11], rsp_first_ff[10:1]};
   assign rsp.second_level  = {~rsp_second_ff[11], rsp_second_ff[10:1]};
   assign rsp.block_end_out = rsp_bend_ff;

endmodule

[src/adpcm_nibble_decoder.sv]
// ADPCM nibble decoder: 4-bit codes in, 12-bit samples and 11-bit PWM levels out.
// req_chan carries one word per command: kind 0 decodes code_byte (high nibble
// first) into one rsp_chan word with both samples; kind 1 loads a step table
// entry, kind 2 an index adjust entry, kind 3 clears predictor and step index.
// Only decode words produce a response; table entries must be loaded first.
// A decode reads both tables, computes the first nibble, reads again at the
// new index and computes the second; this read, index update and second read
// loop sets the decode rate, and no new word is taken mid-decode. One table
// write or restart per cycle while the sequencer is idle.
// A one-word input register takes the next word while the sequencer works, and
// the response register lets the sequencer finish a table write or restart while
// a result waits. When rsp_chan stalls, a decode holds in its last step and
// req_chan stops accepting once the input register fills.
// Reset (synchronous, active high) clears predictor, step index and all valid
// flags; table contents are kept and undefined until written.
`include "adpcm_nibble_decoder_assert.svh"

module adpcm_nibble_decoder #(
   parameter int MAX_STEP_INDEX = andec_pkg::MAX_STEP_INDEX_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   andec_req_if.sink   req_chan,
   andec_rsp_if.source rsp_chan
);
   import andec_pkg::*;

   localparam int IDX_W = $clog2(MAX_STEP_INDEX + 1);

   logic            buf_valid_ff, buf_valid_in;
   item_type        buf_ff;
   core_status_type status;
   tbl_req_type     tbl_req;
   logic [IDX_W-1:0] step_raddr;
   logic [14:0]      step_rdata;
   logic signed [7:0] adj_rdata;
   logic             req_fire;

   assign req_chan.ready = !buf_valid_ff || status.take;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      buf_valid_in = buf_valid_ff;
      if (req_fire) begin
         buf_valid_in = 1'b1;
      end else if (status.take) begin
         buf_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         buf_ff.kind         <= kind_type'(req_chan.kind);
         buf_ff.code_byte    <= req_chan.code_byte;
         buf_ff.table_addr   <= req_chan.table_addr;
         buf_ff.step_value   <= req_chan.step_value;
         buf_ff.adjust_value <= req_chan.adjust_value;
         buf_ff.block_end    <= req_chan.block_end;
      end
   end

   andec_core #(
      .MAX_STEP_INDEX (MAX_STEP_INDEX),
      .IDX_W          (IDX_W)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (buf_valid_ff),
      .cmd        (buf_ff),
      .status     (status),
      .tbl_req    (tbl_req),
      .step_raddr (step_raddr),
      .step_rdata (step_rdata),
      .adj_rdata  (adj_rdata),
      .rsp        (rsp_chan)
   );

   andec_tables #(
      .MAX_STEP_INDEX (MAX_STEP_INDEX),
      .IDX_W          (IDX_W)
   ) u_tables (
      .clock      (clock),
      .tbl_req    (tbl_req),
      .step_raddr (step_raddr),
      .step_rdata (step_rdata),
      .adj_rdata  (adj_rdata)
   );

   `ANDEC_ASSERT_NEXT(a_buf_hold, clock, reset, buf_valid_ff && !status.take, buf_valid_ff, "input word dropped")
   `ANDEC_ASSERT_NOW(a_no_take_busy, clock, reset, status.busy, !status.take, "word taken mid-decode")
   `ANDEC_ASSERT_NOW(a_rsp_from_decode, clock, reset, $rose(rsp_chan.valid), $past(status.busy), "response without decode")

endmodule

[tb/adpcm_decode_checker.sv]
module adpcm_decode_checker import andec_pkg::*; #(
   parameter int MAX_STEP_INDEX = MAX_STEP_INDEX_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   andec_req_if  req_mon,
   andec_rsp_if  rsp_mon,
   output int    mismatch_count,
   output int    pairs_pending
);

   typedef struct packed {
      logic signed [11:0] first_sample;
      logic signed [11:0] second_sample;
      logic [10:0]        first_level;
      logic [10:0]        second_level;
      logic               block_end_out;
   } sample_pair_type;

   logic signed [11:0] predictor;
   logic [5:0]         step_index;
   logic [14:0]        step_mem [0:MAX_STEP_INDEX];
   logic signed [7:0]  adjust_mem [0:ADJ_DEPTH-1];
   sample_pair_type    expected_pairs [$];
   int                 errors;

   // Step index and predictor move per nibble; the step is read before the index moves.
   function automatic logic signed [11:0] decode_nibble(input logic [3:0] code);
      int step;
      int diff;
      int idx;
      int acc;
      step = int'(step_mem[step_index]);
      idx  = int'(step_index) + int'(adjust_mem[code]);
      if (idx < 0) idx = 0;
      if (idx > MAX_STEP_INDEX) idx = MAX_STEP_INDEX;
      step_index = idx[5:0];
      diff = step >> 3;
      if (code[2]) diff += step;
      if (code[1]) diff += step >> 1;
      if (code[0]) diff += step >> 2;
      acc = code[3] ? int'(predictor) - diff : int'(predictor) + diff;
      if (acc < int'(PRED_MIN)) acc = int'(PRED_MIN);
      if (acc > int'(PRED_MAX)) acc = int'(PRED_MAX);
      predictor = acc[11:0];
      return predictor;
   endfunction

   function automatic logic [10:0] pwm_level(input logic signed [11:0] s);
      int v;
      v = (int'(s) + 2048) >> 1;
      return v[10:0];
   endfunction

   function automatic sample_pair_type decode_byte(input logic [7:0] code_byte,
                                                   input logic block_end);
      sample_pair_type p;
      p.first_sample  = decode_nibble(code_byte[7:4]);
      p.second_sample = decode_nibble(code_byte[3:0]);
      p.first_level   = pwm_level(p.first_sample);
      p.second_level  = pwm_level(p.second_sample);
      p.block_end_out = block_end;
      return p;
   endfunction

   always @(posedge clock) begin
      sample_pair_type want;
      sample_pair_type got;
      if (reset) begin
         // tables survive reset
         predictor  = '0;
         step_index = '0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            case (kind_type'(req_mon.kind))
               KIND_DECODE:
                  expected_pairs.push_back(decode_byte(req_mon.code_byte, req_mon.block_end));
               KIND_STEP_WR:
                  if (req_mon.table_addr <= MAX_STEP_INDEX)
                     step_mem[req_mon.table_addr] = req_mon.step_value;
               KIND_ADJ_WR:
                  if (req_mon.table_addr < ADJ_DEPTH)
                     adjust_mem[req_mon.table_addr[3:0]] = req_mon.adjust_value;
               KIND_RESTART: begin
                  predictor  = '0;
                  step_index = '0;
               end
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.first_sample  = rsp_mon.first_sample;
            got.second_sample = rsp_mon.second_sample;
            got.first_level   = rsp_mon.first_level;
            got.second_level  = rsp_mon.second_level;
            got.block_end_out = rsp_mon.block_end_out;
            if (expected_pairs.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected sample word: s=%0d,%0d lvl=%0d,%0d end=%0b",
                           got.first_sample, got.second_sample, got.first_level,
                           got.second_level, got.block_end_out);
            end else begin
               want = expected_pairs.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("sample word mismatch: expected s=%0d,%0d lvl=%0d,%0d end=%0b, %s",
                              want.first_sample, want.second_sample, want.first_level,
                              want.second_level, want.block_end_out,
                              $sformatf("got s=%0d,%0d lvl=%0d,%0d end=%0b",
                                        got.first_sample, got.second_sample,
                                        got.first_level, got.second_level,
                                        got.block_end_out));
               end
            end
         end
      end
      mismatch_count <= errors;
      pairs_pending  <= expected_pairs.size();
   end

endmodule

[tb/tb_adpcm_nibble_decoder.sv]
module tb_adpcm_nibble_decoder;
   import andec_pkg::*;

   localparam int MAX_GAP       = 12;
   localparam int LONG_HOLD     = 400;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_WORDS  = 1900;
   localparam int CHUNKS        = 10;
   localparam int DRAIN_CYCLES  = 32;
   localparam int TOP_INDEX     = MAX_STEP_INDEX_DEFAULT;

   logic clock = 1'b0;
   logic reset = 1'b1;

   andec_req_if req_chan();
   andec_rsp_if rsp_chan();

   int mismatch_count;
   int pairs_pending;
   int sender_gap_max     = MAX_GAP;
   int receiver_stall_max = MAX_GAP;
   bit hold_rsp;
   int n_decodes;
   int n_table_writes;
   int n_restarts;
   int n_results;
   int cycle_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   adpcm_nibble_decoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   adpcm_decode_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .pairs_pending  (pairs_pending)
   );

   // Random junk in every field, then the caller sets what matters.
   function automatic item_type filler(input kind_type k);
      item_type    w;
      logic [63:0] r;
      r = {$urandom, $urandom};
      w = r[$bits(item_type)-1:0];
      w.kind = k;
      return w;
   endfunction

   function automatic item_type random_word();
      item_type w;
      int       pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         w = filler(KIND_DECODE);
         w.block_end = ($urandom_range(0, 7) == 0);
      end else if (pick < 88) begin
         w = filler(KIND_STEP_WR);
         if ($urandom_range(0, 7) != 0) w.table_addr = 6'($urandom_range(0, TOP_INDEX));
         case ($urandom_range(0, 7))
            0:       w.step_value = '0;
            1:       w.step_value = '1;
            2, 3:    ;
            default: w.step_value = 15'($urandom_range(1, 2047));
         endcase
      end else if (pick < 96) begin
         w = filler(KIND_ADJ_WR);
         if ($urandom_range(0, 7) != 0) w.table_addr = 6'($urandom_range(0, ADJ_DEPTH - 1));
         // mostly small index moves, as in real streams
         if ($urandom_range(0, 3) != 0) w.adjust_value = 8'($urandom_range(0, 9) - 1);
      end else begin
         w = filler(KIND_RESTART);
      end
      return w;
   endfunction

   task automatic send_word(input item_type w);
      int gap;
      gap = $urandom_range(0, sender_gap_max);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.kind         <= w.kind;
      req_chan.code_byte    <= w.code_byte;
      req_chan.table_addr   <= w.table_addr;
      req_chan.step_value   <= w.step_value;
      req_chan.adjust_value <= w.adjust_value;
      req_chan.block_end    <= w.block_end;
      req_chan.valid        <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      case (w.kind)
         KIND_DECODE:  n_decodes++;
         KIND_RESTART: n_restarts++;
         default:      n_table_writes++;
      endcase
   endtask

   task automatic send_decode(input logic [7:0] code_byte, input logic block_end);
      item_type w;
      w = filler(KIND_DECODE);
      w.code_byte = code_byte;
      w.block_end = block_end;
      send_word(w);
   endtask

   task automatic send_step(input logic [5:0] addr, input logic [14:0] value);
      item_type w;
      w = filler(KIND_STEP_WR);
      w.table_addr = addr;
      w.step_value = value;
      send_word(w);
   endtask

   task automatic send_adjust(input logic [5:0] addr, input logic signed [7:0] value);
      item_type w;
      w = filler(KIND_ADJ_WR);
      w.table_addr   = addr;
      w.adjust_value = value;
      send_word(w);
   endtask

   // Drop valid so the last word is not offered again, then wait for all results.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (pairs_pending == 0);
   endtask

   initial begin
      int v;
      req_chan.valid        <= 1'b0;
      req_chan.kind         <= '0;
      req_chan.code_byte    <= '0;
      req_chan.table_addr   <= '0;
      req_chan.step_value   <= '0;
      req_chan.adjust_value <= '0;
      req_chan.block_end    <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // load every table entry before the first decode
      v = 7;
      for (int i = 0; i <= TOP_INDEX; i++) begin
         send_step(6'(i), (i == TOP_INDEX) ? 15'h7fff : 15'(v));
         v = v + v / 10 + 1;
      end
      for (int i = 0; i < ADJ_DEPTH; i++)
         send_adjust(6'(i), 8'((i % 8 < 4) ? -1 : 2 * (i % 4 + 1)));

      // writes past the end of either table must drop
      send_step(6'd63, 15'h7fff);
      send_step(6'(TOP_INDEX + 1), 15'h0000);
      send_adjust(6'(ADJ_DEPTH), 8'sd127);
      send_adjust(6'd63, -8'sd128);

      send_decode(8'h00, 1'b0);
      send_decode(8'h77, 1'b1);
      send_decode(8'hff, 1'b0);
      send_decode(8'h88, 1'b1);
      send_decode(8'h7f, 1'b0);
      send_decode(8'hf7, 1'b0);
      send_word(filler(KIND_RESTART));
      // jump to the top index and clamp high, then low
      send_adjust(6'd7, 8'sd127);
      send_decode(8'h77, 1'b0);
      send_decode(8'hff, 1'b1);
      send_adjust(6'd15, -8'sd128);
      send_decode(8'hf0, 1'b0);
      send_word(filler(KIND_RESTART));
      send_decode(8'h5a, 1'b1);
      send_step(6'd0, 15'h0000);
      send_decode(8'h33, 1'b0);
      send_step(6'd0, 15'd7);
      send_adjust(6'd7, 8'sd8);
      send_adjust(6'd15, 8'sd8);
      wait_drained();

      for (int c = 0; c < CHUNKS; c++) begin
         sender_gap_max     = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
         receiver_stall_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
         if (c == 0) begin
            sender_gap_max     = MAX_GAP;
            receiver_stall_max = MAX_GAP;
         end
         if (c == 1) begin
            sender_gap_max     = 0;
            receiver_stall_max = 0;
         end
         if (c == 2) begin
            // hold the output long enough to back up the input
            sender_gap_max = 0;
            hold_rsp       = 1'b1;
         end
         for (int i = 0; i < RANDOM_WORDS / CHUNKS; i++)
            send_word(random_word());
         if (c == 5) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d decode words, %0d table writes, %0d restarts; %0d sample words checked",
               n_decodes, n_table_writes, n_restarts, n_results);
      $display("covered clamping at both rails, ignored out-of-range writes and output backpressure");
      if (mismatch_count == 0 && pairs_pending == 0) begin
         $display("adpcm_nibble_decoder test passed");
      end else begin
         $display("adpcm_nibble_decoder test failed");
      end
      $finish;
   end

   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall    = LONG_HOLD;
         end else begin
            stall = $urandom_range(0, receiver_stall_max);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         n_results++;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("adpcm_nibble_decoder test failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/andec_pkg.sv
src/andec_if.sv
src/andec_tables.sv
src/andec_core.sv
src/adpcm_nibble_decoder.sv
tb/adpcm_decode_checker.sv
tb/tb_adpcm_nibble_decoder.sv
